// ===== rtl/core/cfcps_pkg.sv =====
// shared types, codes and helpers for the class file constant pool scanner
package cfcps_pkg;

    // parse phases
    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_TAG    = 3'd1;
    localparam logic [2:0] PH_LEN    = 3'd2;
    localparam logic [2:0] PH_STR    = 3'd3;
    localparam logic [2:0] PH_OPER   = 3'd4;
    localparam logic [2:0] PH_DONE   = 3'd5;

    // result kinds
    localparam logic [2:0] KIND_STR_BYTE  = 3'd0;
    localparam logic [2:0] KIND_EMPTY_STR = 3'd1;
    localparam logic [2:0] KIND_CLASS_REF = 3'd2;
    localparam logic [2:0] KIND_POOL_DONE = 3'd3;
    localparam logic [2:0] KIND_BAD_MAGIC = 3'd4;
    localparam logic [2:0] KIND_BAD_TAG   = 3'd5;

    // pool entry tags
    localparam logic [7:0] TAG_UTF8    = 8'd1;
    localparam logic [7:0] TAG_UNICODE = 8'd2;
    localparam logic [7:0] TAG_FIRST   = 8'd3;
    localparam logic [7:0] TAG_LONG    = 8'd5;
    localparam logic [7:0] TAG_DOUBLE  = 8'd6;
    localparam logic [7:0] TAG_CLASS   = 8'd7;
    localparam logic [7:0] TAG_STRING  = 8'd8;
    localparam logic [7:0] TAG_LAST    = 8'd12;

    localparam logic [31:0] MAGIC = 32'hCAFE_BABE;

    // header byte positions
    localparam logic [3:0] HPOS_MAGIC_END = 4'd3;
    localparam logic [3:0] HPOS_COUNT_HI  = 4'd8;
    localparam logic [3:0] HPOS_COUNT_LO  = 4'd9;

    localparam int RES_MAX = 4;

    typedef struct packed {
        logic [2:0]  phase;
        logic [3:0]  hpos;
        logic        magic_ok;
        logic [15:0] pool_size;
        logic [15:0] slot;
        logic [3:0]  tag;
        logic [15:0] bytes_left;
        logic [7:0]  held;
        logic        unit_half;
    } t_state;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] entry_index;
        logic [15:0] value;
        logic        string_end;
        logic        last;
    } t_res;

    typedef t_res [RES_MAX-1:0] t_res_vec;

    typedef struct packed {
        logic [1:0] n;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
    } t_utf8;

    localparam t_state STATE_RESET = '{
        phase:      PH_HEADER,
        hpos:       4'd0,
        magic_ok:   1'b1,
        pool_size:  16'd0,
        slot:       16'd0,
        tag:        4'd0,
        bytes_left: 16'd0,
        held:       8'd0,
        unit_half:  1'b0
    };

    // expected magic byte at header position 0..3
    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] b;
        case (idx)
            2'd0:    b = MAGIC[31:24];
            2'd1:    b = MAGIC[23:16];
            2'd2:    b = MAGIC[15:8];
            default: b = MAGIC[7:0];
        endcase
        return b;
    endfunction

    // utf-8 form of one 16-bit unit, zero unit gives the two-byte form
    function automatic t_utf8 utf8_encode(input logic [7:0] hi, input logic [7:0] lo);
        t_utf8 u;
        u = '0;
        if (hi == 8'd0 && lo != 8'd0 && !lo[7]) begin
            u.n  = 2'd1;
            u.b0 = lo;
        end else if (hi[7:3] == 5'd0) begin
            u.n  = 2'd2;
            u.b0 = {3'b110, hi[2:0], lo[7:6]};
            u.b1 = {2'b10, lo[5:0]};
        end else begin
            u.n  = 2'd3;
            u.b0 = {4'hE, hi[7:4]};
            u.b1 = {2'b10, hi[3:0], lo[7:6]};
            u.b2 = {2'b10, lo[5:0]};
        end
        return u;
    endfunction

    function automatic t_res mk_res(input logic [2:0] kind, input logic [15:0] idx,
                                    input logic [15:0] val, input logic str_end);
        t_res r;
        r.kind        = kind;
        r.entry_index = idx;
        r.value       = val;
        r.string_end  = str_end;
        r.last        = 1'b0;
        return r;
    endfunction

endpackage

// ===== rtl/core/cfcps_in_if.sv =====
// input byte channel
interface cfcps_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       restart;

    modport source (output valid, output in_byte, output restart, input ready);
    modport sink   (input valid, input in_byte, input restart, output ready);
endinterface

// ===== rtl/core/cfcps_out_if.sv =====
// result channel
interface cfcps_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [15:0] entry_index;
    logic [15:0] value;
    logic        string_end;
    logic        last;

    modport source (output valid, output kind, output entry_index, output value,
                    output string_end, output last, input ready);
    modport sink   (input valid, input kind, input entry_index, input value,
                    input string_end, input last, output ready);
endinterface

// ===== rtl/core/cfcps_step.sv =====
// next-state and result list for one class file byte
module cfcps_step (
    input  cfcps_pkg::t_state   i_st,
    input  logic [7:0]          i_byte,
    input  logic                i_restart,
    output cfcps_pkg::t_state   o_st,
    output cfcps_pkg::t_res_vec o_res,
    output logic [2:0]          o_cnt
);
    import cfcps_pkg::*;

    always_comb begin
        t_state     s;
        t_state     n;
        t_res_vec   r;
        t_utf8      u;
        logic [2:0] c;
        logic [15:0] bl;
        logic [16:0] nxt;
        logic       fin;
        logic [1:0] adv;
        logic       do_unit;
        logic       uend;
        logic [7:0] uhi;
        logic [7:0] ulo;
        logic [7:0] ub;

        s       = i_restart ? STATE_RESET : i_st;
        n       = s;
        r       = '0;
        c       = 3'd0;
        bl      = s.bytes_left - 16'd1;
        fin     = 1'b0;
        adv     = 2'd1;
        do_unit = 1'b0;
        uend    = 1'b0;
        uhi     = 8'd0;
        ulo     = 8'd0;
        nxt     = 17'd0;
        ub      = 8'd0;

        case (s.phase)
            // magic, versions and pool count
            PH_HEADER: begin
                if (s.hpos < 4'd4 && i_byte != magic_byte(s.hpos[1:0]))
                    n.magic_ok = 1'b0;
                if (s.hpos >= HPOS_COUNT_HI)
                    n.pool_size = {s.pool_size[7:0], i_byte};
                if (s.hpos == HPOS_MAGIC_END && !n.magic_ok) begin
                    r[c[1:0]] = mk_res(KIND_BAD_MAGIC, 16'd0, 16'd0, 1'b0);
                    c = c + 3'd1;
                    n.phase = PH_DONE;
                end else if (s.hpos == HPOS_COUNT_LO) begin
                    if (n.pool_size <= 16'd1) begin
                        r[c[1:0]] = mk_res(KIND_POOL_DONE, n.pool_size, 16'd0, 1'b0);
                        c = c + 3'd1;
                        n.phase = PH_DONE;
                    end else begin
                        n.slot  = 16'd1;
                        n.phase = PH_TAG;
                    end
                end
                n.hpos = s.hpos + 4'd1;
            end
            // entry tag
            PH_TAG: begin
                if (i_byte == TAG_UTF8 || i_byte == TAG_UNICODE) begin
                    n.tag       = i_byte[3:0];
                    n.unit_half = 1'b0;
                    n.phase     = PH_LEN;
                end else if (i_byte >= TAG_FIRST && i_byte <= TAG_LAST) begin
                    n.tag = i_byte[3:0];
                    if (i_byte == TAG_LONG || i_byte == TAG_DOUBLE)
                        n.bytes_left = 16'd8;
                    else if (i_byte == TAG_CLASS || i_byte == TAG_STRING)
                        n.bytes_left = 16'd2;
                    else
                        n.bytes_left = 16'd4;
                    n.phase = PH_OPER;
                end else begin
                    r[c[1:0]] = mk_res(KIND_BAD_TAG, s.slot, {8'd0, i_byte}, 1'b0);
                    c = c + 3'd1;
                    n.phase = PH_DONE;
                end
            end
            // string length, high byte first
            PH_LEN: begin
                if (!s.unit_half) begin
                    n.held      = i_byte;
                    n.unit_half = 1'b1;
                end else begin
                    n.unit_half = 1'b0;
                    if ({s.held, i_byte} == 16'd0) begin
                        r[c[1:0]] = mk_res(KIND_EMPTY_STR, s.slot, 16'd0, 1'b1);
                        c = c + 3'd1;
                        fin = 1'b1;
                    end else begin
                        n.bytes_left = {s.held, i_byte};
                        n.phase      = PH_STR;
                    end
                end
            end
            // string body
            PH_STR: begin
                n.bytes_left = bl;
                if (s.tag == TAG_UTF8[3:0]) begin
                    r[c[1:0]] = mk_res(KIND_STR_BYTE, s.slot, {8'd0, i_byte}, bl == 16'd0);
                    c = c + 3'd1;
                end else if (!s.unit_half) begin
                    n.held      = i_byte;
                    n.unit_half = 1'b1;
                    if (bl == 16'd0) begin
                        n.unit_half = 1'b0;
                        do_unit     = 1'b1;
                        uhi         = i_byte;
                        ulo         = 8'd0;
                        uend        = 1'b1;
                    end
                end else begin
                    n.unit_half = 1'b0;
                    do_unit     = 1'b1;
                    uhi         = s.held;
                    ulo         = i_byte;
                    uend        = (bl == 16'd0);
                end
                if (bl == 16'd0)
                    fin = 1'b1;
            end
            // fixed-size operands
            PH_OPER: begin
                if (s.tag == TAG_CLASS[3:0] && s.bytes_left == 16'd2)
                    n.held = i_byte;
                n.bytes_left = bl;
                if (bl == 16'd0) begin
                    if (s.tag == TAG_CLASS[3:0]) begin
                        r[c[1:0]] = mk_res(KIND_CLASS_REF, s.slot, {n.held, i_byte}, 1'b0);
                        c = c + 3'd1;
                    end
                    fin = 1'b1;
                    if (s.tag == TAG_LONG[3:0] || s.tag == TAG_DOUBLE[3:0])
                        adv = 2'd2;
                end
            end
            default: begin
                n.phase = PH_DONE;
            end
        endcase

        // recoded unicode unit, one to three bytes
        u = utf8_encode(uhi, ulo);
        for (int k = 0; k < 3; k++) begin
            if (do_unit && k < int'(u.n)) begin
                case (k)
                    0:       ub = u.b0;
                    1:       ub = u.b1;
                    default: ub = u.b2;
                endcase
                r[c[1:0]] = mk_res(KIND_STR_BYTE, s.slot, {8'd0, ub},
                                   uend && (k == int'(u.n) - 1));
                c = c + 3'd1;
            end
        end

        // step to the next slot or close the pool
        if (fin) begin
            nxt = {1'b0, s.slot} + {15'd0, adv};
            if (nxt >= {1'b0, s.pool_size}) begin
                r[c[1:0]] = mk_res(KIND_POOL_DONE, s.pool_size, 16'd0, 1'b0);
                c = c + 3'd1;
                n.phase = PH_DONE;
            end else begin
                n.slot  = nxt[15:0];
                n.phase = PH_TAG;
            end
        end

        // mark the final result of this byte
        for (int k = 0; k < RES_MAX; k++)
            r[k].last = (c != 3'd0) && (k == int'(c) - 1);

        o_st  = n;
        o_res = r;
        o_cnt = c;
    end

endmodule

// ===== rtl/core/class_file_constant_pool_scanner.sv =====
// top level of the class file constant pool scanner
//
// Usage: i_in carries one class file byte per transfer, with restart high on
// the first byte of each file. o_out carries the results: string bytes in
// UTF-8 (tag 2 strings recoded from 16-bit units), empty strings, class name
// indexes, bad magic and unknown tag, each with its pool slot, and pool done
// with the pool count. Every byte is decoded in the cycle it is taken; its
// results (zero to four) land in a four-entry result register. While
// o_out.ready is high they leave one per cycle, the first in the cycle after
// the byte transfer, and bytes giving zero or one result, as plain pool data
// does, pass at one byte per cycle; a byte giving more holds i_in.ready low
// while the result register drains. A new byte is taken in the same cycle the
// last waiting result transfers. When o_out.ready is low the results hold and
// i_in.ready drops once a byte's results are waiting. Reset clears the parser
// to the header state and empties the result register. After pool done or an
// error, bytes are taken and dropped until a restart byte.
module class_file_constant_pool_scanner (
    input  logic            i_clk,
    input  logic            i_rst_n,
    cfcps_in_if.sink        i_in,
    cfcps_out_if.source     o_out
);
    import cfcps_pkg::*;

    t_state     r_st;
    t_state     n_st;
    t_res_vec   r_buf;
    t_res_vec   n_res;
    logic [2:0] r_cnt;
    logic [2:0] n_cnt;
    logic [1:0] r_head;
    logic       in_xfer;
    logic       out_xfer;
    t_res       cur;

    cfcps_step u_step (
        .i_st      (r_st),
        .i_byte    (i_in.in_byte),
        .i_restart (i_in.restart),
        .o_st      (n_st),
        .o_res     (n_res),
        .o_cnt     (n_cnt)
    );

    // handshakes
    assign i_in.ready = (r_cnt == 3'd0) || (r_cnt == 3'd1 && o_out.ready);
    assign in_xfer    = i_in.valid && i_in.ready;
    assign out_xfer   = o_out.valid && o_out.ready;

    // parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= STATE_RESET;
        end else if (in_xfer) begin
            r_st <= n_st;
        end
    end

    // result register and drain pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 3'd0;
            r_head <= 2'd0;
        end else if (in_xfer) begin
            r_cnt  <= n_cnt;
            r_head <= 2'd0;
        end else if (out_xfer) begin
            r_cnt  <= r_cnt - 3'd1;
            r_head <= r_head + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_buf <= n_res;
        end
    end

    // output fields
    assign cur               = r_buf[r_head];
    assign o_out.valid       = (r_cnt != 3'd0);
    assign o_out.kind        = cur.kind;
    assign o_out.entry_index = cur.entry_index;
    assign o_out.value       = cur.value;
    assign o_out.string_end  = cur.string_end;
    assign o_out.last        = cur.last;

endmodule

// ===== bench/testbench.sv =====
// testbench for the class file constant pool scanner: directed table plus random class files
`timescale 1ns / 100ps

module testbench;
    import cfcps_pkg::*;

    localparam int DIR_LEN      = 21;
    localparam int RANDOM_ITEMS = 500;
    localparam int QUIET_ITEMS  = 80;
    localparam int HOLD_CYCLES  = 300;

    // one row of the directed table, want is used only where typed is set
    typedef struct packed {
        logic [7:0] b;
        logic       rs;
        logic       typed;
        t_res       want;
    } t_dir_row;

    // predicted parser state
    typedef struct {
        logic [2:0]  phase;
        logic [3:0]  hpos;
        logic        magic_ok;
        logic [15:0] count;
        logic [15:0] slot;
        logic [3:0]  tag;
        logic [15:0] left;
        logic [7:0]  held;
        logic        half;
    } t_scan_state;

    localparam t_res NO_RES    = '0;
    localparam t_res MAGIC_ERR = '{kind: KIND_BAD_MAGIC, entry_index: 16'd0, value: 16'd0,
                                   string_end: 1'b0, last: 1'b1};
    localparam t_res TAG_ERR   = '{kind: KIND_BAD_TAG, entry_index: 16'd2, value: 16'h00FF,
                                   string_end: 1'b0, last: 1'b1};

    // bad magic, then a three-slot file: unicode string with a zero unit and an odd
    // trailing byte, then an unknown tag
    localparam t_dir_row DIR_ROWS [DIR_LEN] = '{
        '{8'h00, 1'b1, 1'b0, NO_RES},
        '{8'hFE, 1'b0, 1'b0, NO_RES},
        '{8'hBA, 1'b0, 1'b0, NO_RES},
        '{8'hBE, 1'b0, 1'b1, MAGIC_ERR},
        '{8'hCA, 1'b1, 1'b0, NO_RES},
        '{8'hFE, 1'b0, 1'b0, NO_RES},
        '{8'hBA, 1'b0, 1'b0, NO_RES},
        '{8'hBE, 1'b0, 1'b0, NO_RES},
        '{8'hFF, 1'b0, 1'b0, NO_RES},
        '{8'hFF, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b0, NO_RES},
        '{8'h03, 1'b0, 1'b0, NO_RES},
        '{8'h02, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b0, NO_RES},
        '{8'h03, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b0, NO_RES},
        '{8'hFF, 1'b0, 1'b0, NO_RES},
        '{8'hFF, 1'b0, 1'b1, TAG_ERR}
    };

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    cfcps_in_if  in_ch ();
    cfcps_out_if out_ch ();

    class_file_constant_pool_scanner dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_scan_state ps;
    t_res        byte_out [$];
    t_res        pool_results_due [$];
    t_res        want_res;
    t_res        got_res;
    int          error_count = 0;
    int          items_sent  = 0;
    bit          quiet       = 1'b0;
    bit          hold_req    = 1'b0;
    bit          hold_done   = 1'b0;
    bit          pause_done  = 1'b0;

    // clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // run limit
    initial begin
        #1_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // parser prediction
    task automatic reset_scan();
        ps.phase    = PH_HEADER;
        ps.hpos     = 4'd0;
        ps.magic_ok = 1'b1;
        ps.count    = 16'd0;
        ps.slot     = 16'd0;
        ps.tag      = 4'd0;
        ps.left     = 16'd0;
        ps.held     = 8'd0;
        ps.half     = 1'b0;
    endtask

    task automatic add_result(input logic [2:0] kind, input logic [15:0] idx,
                              input logic [15:0] val, input logic fin);
        t_res r;
        r.kind        = kind;
        r.entry_index = idx;
        r.value       = val;
        r.string_end  = fin;
        r.last        = 1'b0;
        if (byte_out.size() < RES_MAX) byte_out.push_back(r);
    endtask

    // utf-8 bytes of one 16-bit unit, zero unit takes the two-byte form
    task automatic add_unit(input logic [7:0] hi, input logic [7:0] lo, input logic fin);
        if (hi == 8'd0 && lo != 8'd0 && !lo[7]) begin
            add_result(KIND_STR_BYTE, ps.slot, {8'h00, lo}, fin);
        end else if (hi[7:3] == 5'd0) begin
            add_result(KIND_STR_BYTE, ps.slot, {8'h00, 3'b110, hi[2:0], lo[7:6]}, 1'b0);
            add_result(KIND_STR_BYTE, ps.slot, {8'h00, 2'b10, lo[5:0]}, fin);
        end else begin
            add_result(KIND_STR_BYTE, ps.slot, {8'h00, 4'hE, hi[7:4]}, 1'b0);
            add_result(KIND_STR_BYTE, ps.slot, {8'h00, 2'b10, hi[3:0], lo[7:6]}, 1'b0);
            add_result(KIND_STR_BYTE, ps.slot, {8'h00, 2'b10, lo[5:0]}, fin);
        end
    endtask

    // move to the next slot or report pool done
    task automatic close_entry(input logic [1:0] adv);
        logic [16:0] nxt;
        nxt = {1'b0, ps.slot} + adv;
        if (nxt >= {1'b0, ps.count}) begin
            add_result(KIND_POOL_DONE, ps.count, 16'd0, 1'b0);
            ps.phase = PH_DONE;
        end else begin
            ps.slot  = nxt[15:0];
            ps.phase = PH_TAG;
        end
    endtask

    task automatic decode_class_byte(input logic [7:0] b, input logic rs);
        logic [15:0] len;
        byte_out.delete();
        if (rs) reset_scan();
        case (ps.phase)
            PH_HEADER: begin
                if (ps.hpos < 4'd4 && b != MAGIC[8*(3 - ps.hpos[1:0]) +: 8])
                    ps.magic_ok = 1'b0;
                if (ps.hpos >= HPOS_COUNT_HI) ps.count = {ps.count[7:0], b};
                if (ps.hpos == HPOS_MAGIC_END && !ps.magic_ok) begin
                    add_result(KIND_BAD_MAGIC, 16'd0, 16'd0, 1'b0);
                    ps.phase = PH_DONE;
                end else if (ps.hpos == HPOS_COUNT_LO) begin
                    if (ps.count <= 16'd1) begin
                        add_result(KIND_POOL_DONE, ps.count, 16'd0, 1'b0);
                        ps.phase = PH_DONE;
                    end else begin
                        ps.slot  = 16'd1;
                        ps.phase = PH_TAG;
                    end
                end
                ps.hpos = ps.hpos + 4'd1;
            end
            PH_TAG: begin
                if (b == TAG_UTF8 || b == TAG_UNICODE) begin
                    ps.tag   = b[3:0];
                    ps.half  = 1'b0;
                    ps.phase = PH_LEN;
                end else if (b >= TAG_FIRST && b <= TAG_LAST) begin
                    ps.tag = b[3:0];
                    if (b == TAG_LONG || b == TAG_DOUBLE) ps.left = 16'd8;
                    else if (b == TAG_CLASS || b == TAG_STRING) ps.left = 16'd2;
                    else ps.left = 16'd4;
                    ps.phase = PH_OPER;
                end else begin
                    add_result(KIND_BAD_TAG, ps.slot, {8'h00, b}, 1'b0);
                    ps.phase = PH_DONE;
                end
            end
            PH_LEN: begin
                if (!ps.half) begin
                    ps.held = b;
                    ps.half = 1'b1;
                end else begin
                    len     = {ps.held, b};
                    ps.half = 1'b0;
                    if (len == 16'd0) begin
                        add_result(KIND_EMPTY_STR, ps.slot, 16'd0, 1'b1);
                        close_entry(2'd1);
                    end else begin
                        ps.left  = len;
                        ps.phase = PH_STR;
                    end
                end
            end
            PH_STR: begin
                ps.left = ps.left - 16'd1;
                if (ps.tag == TAG_UTF8) begin
                    add_result(KIND_STR_BYTE, ps.slot, {8'h00, b}, ps.left == 16'd0);
                end else if (!ps.half) begin
                    ps.held = b;
                    ps.half = 1'b1;
                    // odd trailing byte: high half of a unit with a zero low half
                    if (ps.left == 16'd0) begin
                        ps.half = 1'b0;
                        add_unit(ps.held, 8'd0, 1'b1);
                    end
                end else begin
                    ps.half = 1'b0;
                    add_unit(ps.held, b, ps.left == 16'd0);
                end
                if (ps.left == 16'd0) close_entry(2'd1);
            end
            PH_OPER: begin
                if (ps.tag == TAG_CLASS && ps.left == 16'd2) ps.held = b;
                ps.left = ps.left - 16'd1;
                if (ps.left == 16'd0) begin
                    if (ps.tag == TAG_CLASS)
                        add_result(KIND_CLASS_REF, ps.slot, {ps.held, b}, 1'b0);
                    close_entry((ps.tag == TAG_LONG || ps.tag == TAG_DOUBLE) ? 2'd2 : 2'd1);
                end
            end
            default: begin
                ps.phase = PH_DONE;
            end
        endcase
        if (byte_out.size() > 0) byte_out[byte_out.size()-1].last = 1'b1;
    endtask

    // offer one byte and wait for its transfer
    task automatic offer_byte(input logic [7:0] b, input logic rs, input logic typed,
                              input t_res want);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        decode_class_byte(b, rs);
        if (typed) pool_results_due.push_back(want);
        else foreach (byte_out[k]) pool_results_due.push_back(byte_out[k]);
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= b;
        in_ch.restart <= rs;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        items_sent++;
        if (items_sent >= DIR_LEN + RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
    endtask

    // sender pauses until every predicted result has come out
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pool_results_due.size() != 0);
    endtask

    // up to two bytes past the end of a file, dropped by the block
    task automatic send_tail();
        repeat ($urandom_range(0, 2)) offer_byte(8'($urandom), 1'b0, 1'b0, NO_RES);
    endtask

    // one class file: mostly well formed, sometimes a bad magic, an unknown tag or cut short
    task automatic send_random_file();
        logic [15:0] count;
        logic [7:0]  b;
        logic [7:0]  tg;
        logic        broken;
        int          slot;
        int          len;
        int          sel;
        broken = 1'b0;
        for (int i = 0; i < 4; i++) begin
            b = MAGIC[8*(3-i) +: 8];
            if ($urandom_range(0, 24) == 0) b = 8'($urandom);
            if (b != MAGIC[8*(3-i) +: 8]) broken = 1'b1;
            offer_byte(b, i == 0, 1'b0, NO_RES);
        end
        if (broken) begin
            send_tail();
            return;
        end
        repeat (4) offer_byte(8'($urandom), 1'b0, 1'b0, NO_RES);
        sel = $urandom_range(0, 15);
        if (sel == 0) count = 16'($urandom);
        else if (sel < 3) count = 16'(sel - 1);
        else count = 16'($urandom_range(2, 8));
        offer_byte(count[15:8], 1'b0, 1'b0, NO_RES);
        offer_byte(count[7:0], 1'b0, 1'b0, NO_RES);
        if (count <= 16'd1) begin
            send_tail();
            return;
        end
        slot = 1;
        while (slot < count) begin
            // cut large pools short, the next file restarts the parser
            if (slot > 10 || $urandom_range(0, 39) == 0) return;
            sel = $urandom_range(0, 31);
            if (sel == 0) begin
                tg = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(13, 255));
                offer_byte(tg, 1'b0, 1'b0, NO_RES);
                send_tail();
                return;
            end else if (sel <= 9) begin
                tg = TAG_UTF8;
            end else if (sel <= 18) begin
                tg = TAG_UNICODE;
            end else if (sel <= 22) begin
                tg = TAG_CLASS;
            end else begin
                tg = 8'($urandom_range(TAG_FIRST, TAG_LAST));
            end
            offer_byte(tg, 1'b0, 1'b0, NO_RES);
            if (tg == TAG_UTF8 || tg == TAG_UNICODE) begin
                len = ($urandom_range(0, 63) == 0) ? $urandom_range(250, 300)
                                                   : $urandom_range(0, 9);
                offer_byte(8'(len >> 8), 1'b0, 1'b0, NO_RES);
                offer_byte(8'(len), 1'b0, 1'b0, NO_RES);
                for (int j = 0; j < len; j++) begin
                    // unicode units lean toward the one, two and three byte boundaries
                    sel = $urandom_range(0, 3);
                    if (tg == TAG_UTF8 || sel >= 2) b = 8'($urandom);
                    else if (sel == 0) b = 8'd0;
                    else b = (j % 2 == 0) ? 8'($urandom_range(0, 7))
                                          : 8'($urandom_range(1, 127));
                    offer_byte(b, 1'b0, 1'b0, NO_RES);
                end
                slot++;
            end else begin
                if (tg == TAG_LONG || tg == TAG_DOUBLE) len = 8;
                else if (tg == TAG_CLASS || tg == TAG_STRING) len = 2;
                else len = 4;
                repeat (len) offer_byte(8'($urandom), 1'b0, 1'b0, NO_RES);
                slot += (tg == TAG_LONG || tg == TAG_DOUBLE) ? 2 : 1;
            end
        end
        send_tail();
    endtask

    // result receiver with random stalls and one long hold-off
    initial begin
        out_ch.ready <= 1'b0;
        repeat (3) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    // compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got_res = '{kind: out_ch.kind, entry_index: out_ch.entry_index,
                        value: out_ch.value, string_end: out_ch.string_end,
                        last: out_ch.last};
            if (pool_results_due.size() == 0) begin
                $display("%0t: unexpected result: expected none", $time);
                $display("%0t:   actual kind %0d index %0d value %h end %b last %b",
                         $time, got_res.kind, got_res.entry_index, got_res.value,
                         got_res.string_end, got_res.last);
                error_count++;
            end else begin
                want_res = pool_results_due.pop_front();
                if (got_res !== want_res) begin
                    $display("%0t: mismatch: expected kind %0d index %0d value %h end %b last %b",
                             $time, want_res.kind, want_res.entry_index, want_res.value,
                             want_res.string_end, want_res.last);
                    $display("%0t:           actual kind %0d index %0d value %h end %b last %b",
                             $time, got_res.kind, got_res.entry_index, got_res.value,
                             got_res.string_end, got_res.last);
                    error_count++;
                end
            end
        end
    end

    // stimulus
    initial begin
        in_ch.valid   <= 1'b0;
        in_ch.in_byte <= 8'd0;
        in_ch.restart <= 1'b0;
        reset_scan();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < DIR_LEN; k++)
            offer_byte(DIR_ROWS[k].b, DIR_ROWS[k].rs, DIR_ROWS[k].typed, DIR_ROWS[k].want);
        wait_drained();

        while (items_sent < DIR_LEN + RANDOM_ITEMS) begin
            if (!hold_done && items_sent >= 150) begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            if (!pause_done && items_sent >= 350) begin
                wait_drained();
                pause_done = 1'b1;
            end
            send_random_file();
        end
        in_ch.valid <= 1'b0;

        while (pool_results_due.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
